// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape block.
// Holds the decoder mode encoding, result codes and the result group types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_BODY     = 4'd1,
      MODE_ESC      = 4'd2,
      MODE_HEX      = 4'd3,
      MODE_PAIR_BS  = 4'd4,
      MODE_PAIR_U   = 4'd5,
      MODE_PAIR_HEX = 4'd6
   } mode_type;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
   localparam logic [2:0] ERR_UNTERM     = 3'd2;
   localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd4;
   localparam logic [2:0] ERR_BAD_CP     = 3'd5;
   localparam logic [2:0] ERR_BAD_PAIR   = 3'd6;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_BS_CTL    = 8'h08;
   localparam logic [7:0] CHAR_FF_CTL    = 8'h0C;
   localparam logic [7:0] CHAR_LF_CTL    = 8'h0A;
   localparam logic [7:0] CHAR_CR_CTL    = 8'h0D;
   localparam logic [7:0] CHAR_TAB_CTL   = 8'h09;

   localparam int unsigned MAX_RESULTS = 4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [2:0] error_code;
      logic       last;
   } result_type;

   // One input byte's worth of results, oldest in slot zero.
   typedef struct packed {
      logic [2:0]                         count;
      result_type [MAX_RESULTS-1:0]       items;
   } group_type;

endpackage

`default_nettype wire

// ===== rtl/jsu_decode.sv =====
// Decoder state and per-byte decode logic for the JSON string unescape block.
// Produces the group of results for one byte. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       in_byte,
   output jsu_pkg::group_type    group
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [15:0] hex_ff, hex_in;
   logic [1:0]  digits_ff, digits_in;
   logic [9:0]  high_ff, high_in;

   logic        err;
   logic [2:0]  err_code;
   logic        emit_one;
   logic [1:0]  one_kind;
   logic [7:0]  one_byte;
   logic        emit_cp;
   logic [20:0] cp;
   logic        nib_ok;
   logic [3:0]  nib;
   logic [15:0] hex_next;
   logic [20:0] pair_cp;

   function automatic jsu_pkg::result_type mk(input logic [7:0] b, input logic [1:0] k,
                                              input logic [2:0] e);
      jsu_pkg::result_type r;
      r.out_byte   = b;
      r.kind       = k;
      r.error_code = e;
      r.last       = 1'b0;
      return r;
   endfunction

   always_comb begin
      nib_ok = 1'b1;
      nib    = 4'd0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         nib = in_byte[3:0];
      end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         nib = in_byte[3:0] + 4'd9;
      end else begin
         nib_ok = 1'b0;
      end
   end

   assign hex_next = {hex_ff[11:0], nib};
   assign pair_cp  = 21'h10000 + {1'b0, high_ff, hex_next[9:0]};

   always_comb begin
      mode_in   = mode_ff;
      hex_in    = hex_ff;
      digits_in = digits_ff;
      high_in   = high_ff;
      err       = 1'b0;
      err_code  = jsu_pkg::ERR_NONE;
      emit_one  = 1'b0;
      one_kind  = jsu_pkg::KIND_BYTE;
      one_byte  = 8'd0;
      emit_cp   = 1'b0;
      cp        = 21'd0;

      if (!(mode_ff inside {[jsu_pkg::MODE_BODY : jsu_pkg::MODE_PAIR_HEX]})) begin
         // Idle, and any unused encoding behaves as idle.
         if (in_byte != jsu_pkg::CHAR_QUOTE) begin
            err      = 1'b1;
            err_code = jsu_pkg::ERR_NO_QUOTE;
         end else begin
            mode_in = jsu_pkg::MODE_BODY;
         end
      end else if (in_byte == jsu_pkg::CHAR_NUL) begin
         err      = 1'b1;
         err_code = jsu_pkg::ERR_UNTERM;
      end else begin
         case (mode_ff)
            jsu_pkg::MODE_BODY: begin
               if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                  mode_in  = jsu_pkg::MODE_IDLE;
                  emit_one = 1'b1;
                  one_kind = jsu_pkg::KIND_END;
               end else if (in_byte == jsu_pkg::CHAR_BACKSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end else begin
                  emit_one = 1'b1;
                  one_byte = in_byte;
               end
            end
            jsu_pkg::MODE_ESC: begin
               mode_in  = jsu_pkg::MODE_BODY;
               emit_one = 1'b1;
               case (in_byte)
                  jsu_pkg::CHAR_QUOTE:     one_byte = jsu_pkg::CHAR_QUOTE;
                  jsu_pkg::CHAR_BACKSLASH: one_byte = jsu_pkg::CHAR_BACKSLASH;
                  jsu_pkg::CHAR_SLASH:     one_byte = jsu_pkg::CHAR_SLASH;
                  jsu_pkg::CHAR_B:         one_byte = jsu_pkg::CHAR_BS_CTL;
                  jsu_pkg::CHAR_F:         one_byte = jsu_pkg::CHAR_FF_CTL;
                  jsu_pkg::CHAR_N:         one_byte = jsu_pkg::CHAR_LF_CTL;
                  jsu_pkg::CHAR_R:         one_byte = jsu_pkg::CHAR_CR_CTL;
                  jsu_pkg::CHAR_T:         one_byte = jsu_pkg::CHAR_TAB_CTL;
                  jsu_pkg::CHAR_U: begin
                     emit_one  = 1'b0;
                     mode_in   = jsu_pkg::MODE_HEX;
                     hex_in    = 16'd0;
                     digits_in = 2'd0;
                  end
                  default: begin
                     emit_one = 1'b0;
                     err      = 1'b1;
                     err_code = jsu_pkg::ERR_BAD_ESC;
                  end
               endcase
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_PAIR_HEX: begin
               if (!nib_ok) begin
                  err      = 1'b1;
                  err_code = (mode_ff == jsu_pkg::MODE_HEX) ? jsu_pkg::ERR_BAD_HEX
                                                           : jsu_pkg::ERR_BAD_PAIR;
               end else if (digits_ff != 2'd3) begin
                  hex_in    = hex_next;
                  digits_in = digits_ff + 2'd1;
               end else begin
                  hex_in    = 16'd0;
                  digits_in = 2'd0;
                  if (mode_ff == jsu_pkg::MODE_HEX) begin
                     if (hex_next == 16'd0 || hex_next inside {[16'hDC00:16'hDFFF]}) begin
                        err      = 1'b1;
                        err_code = jsu_pkg::ERR_BAD_CP;
                     end else if (hex_next inside {[16'hD800:16'hDBFF]}) begin
                        high_in = hex_next[9:0];
                        mode_in = jsu_pkg::MODE_PAIR_BS;
                     end else begin
                        mode_in = jsu_pkg::MODE_BODY;
                        emit_cp = 1'b1;
                        cp      = {5'd0, hex_next};
                     end
                  end else begin
                     if (!(hex_next inside {[16'hDC00:16'hDFFF]})) begin
                        err      = 1'b1;
                        err_code = jsu_pkg::ERR_BAD_PAIR;
                     end else begin
                        high_in = 10'd0;
                        mode_in = jsu_pkg::MODE_BODY;
                        emit_cp = 1'b1;
                        cp      = pair_cp;
                     end
                  end
               end
            end
            jsu_pkg::MODE_PAIR_BS: begin
               if (in_byte != jsu_pkg::CHAR_BACKSLASH) begin
                  err      = 1'b1;
                  err_code = jsu_pkg::ERR_BAD_PAIR;
               end else begin
                  mode_in = jsu_pkg::MODE_PAIR_U;
               end
            end
            default: begin
               // Waiting for the 'u' of the low surrogate escape.
               if (in_byte != jsu_pkg::CHAR_U) begin
                  err      = 1'b1;
                  err_code = jsu_pkg::ERR_BAD_PAIR;
               end else begin
                  mode_in   = jsu_pkg::MODE_PAIR_HEX;
                  hex_in    = 16'd0;
                  digits_in = 2'd0;
               end
            end
         endcase
      end

      if (err) begin
         mode_in   = jsu_pkg::MODE_IDLE;
         hex_in    = 16'd0;
         digits_in = 2'd0;
         high_in   = 10'd0;
      end
   end

   // Result group assembly, including the UTF-8 encoder.
   always_comb begin
      group.count = 3'd0;
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         group.items[i] = mk(8'd0, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
      end
      if (err) begin
         group.count    = 3'd1;
         group.items[0] = mk(8'd0, jsu_pkg::KIND_ERROR, err_code);
      end else if (emit_one) begin
         group.count    = 3'd1;
         group.items[0] = mk(one_byte, one_kind, jsu_pkg::ERR_NONE);
      end else if (emit_cp) begin
         if (cp < 21'h80) begin
            group.count    = 3'd1;
            group.items[0] = mk(cp[7:0], jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
         end else if (cp < 21'h800) begin
            group.count    = 3'd2;
            group.items[0] = mk({3'b110, cp[10:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            group.items[1] = mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
         end else if (cp < 21'h10000) begin
            group.count    = 3'd3;
            group.items[0] = mk({4'b1110, cp[15:12]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            group.items[1] = mk({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            group.items[2] = mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
         end else begin
            group.count    = 3'd4;
            group.items[0] = mk({5'b11110, cp[20:18]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            group.items[1] = mk({2'b10, cp[17:12]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            group.items[2] = mk({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            group.items[3] = mk({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
         end
      end
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         group.items[i].last = (group.count == 3'(i + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= jsu_pkg::MODE_IDLE;
         hex_ff    <= 16'd0;
         digits_ff <= 2'd0;
         high_ff   <= 10'd0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         hex_ff    <= hex_in;
         digits_ff <= digits_in;
         high_ff   <= high_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/jsu_serializer.sv =====
// Result register for the JSON string unescape block: holds one group of
// up to four results and hands them out one per transaction. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_serializer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             group_valid,
   input  wire jsu_pkg::group_type group,
   output logic                  group_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output jsu_pkg::result_type   rsp_item
);

   logic [2:0] count_ff, count_in;
   logic [1:0] index_ff, index_in;
   jsu_pkg::result_type [jsu_pkg::MAX_RESULTS-1:0] items_ff, items_in;
   logic pop;
   logic draining;
   logic load;

   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_item    = items_ff[index_ff];
   assign pop         = rsp_valid && rsp_ready;
   // The last held result leaves this cycle, so a new group may take its place.
   assign draining    = pop && ({1'b0, index_ff} == (count_ff - 3'd1));
   assign group_ready = !rsp_valid || draining;
   assign load        = group_valid && group_ready;

   always_comb begin
      count_in = count_ff;
      index_in = index_ff;
      items_in = items_ff;
      if (load) begin
         count_in = group.count;
         index_in = 2'd0;
         items_in = group.items;
      end else if (draining) begin
         count_in = 3'd0;
         index_in = 2'd0;
      end else if (pop) begin
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         index_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
      items_ff <= items_in;
   end

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescape block: input register, decoder and
// result serializer. Depends on jsu_pkg, jsu_decode and jsu_serializer.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  req_in_byte (8 bits)
//   rsp_      out        rsp_valid / rsp_ready  rsp_out_byte, rsp_kind,
//                                               rsp_error_code, rsp_last
//
// Each accepted byte is held in the input register and is decoded
// from there into a group of zero to four results held in the result
// register. Bytes that give at most one result stream at one per cycle
// while rsp_ready is held; a byte that gives n results holds the result
// register until all n are taken, so the result port sets the rate.
// Reset is synchronous and returns the decoder to idle, waiting for a quote.
// A stalled result port fills the result register, then the input register,
// and then req_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_kind,
   output logic [2:0]      rsp_error_code,
   output logic            rsp_last
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       group_ready;
   logic       advance;
   jsu_pkg::group_type  group;
   jsu_pkg::result_type rsp_item;

   // The held byte is decoded in the cycle that the result register can take
   // its group; the decoder state moves at that same edge.
   assign advance   = in_valid_ff && group_ready;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .in_byte (in_byte_ff),
      .group   (group)
   );

   jsu_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .group_valid (in_valid_ff),
      .group       (group),
      .group_ready (group_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

   assign rsp_out_byte   = rsp_item.out_byte;
   assign rsp_kind       = rsp_item.kind;
   assign rsp_error_code = rsp_item.error_code;
   assign rsp_last       = rsp_item.last;

endmodule

`default_nettype wire
